// ===== rtl/core/svm_pkg.sv =====
// ----------------------------------------------------------------------------
// svm_pkg
// Shared types, sizes and codes of the stack machine execution unit.
// ----------------------------------------------------------------------------
package svm_pkg;

  localparam int unsigned VS_DEPTH   = 1024;
  localparam int unsigned CS_DEPTH   = 256;
  localparam int unsigned HEAP_DEPTH = 4096;
  localparam int unsigned PC_W       = 16;

  localparam int unsigned VS_AW = (VS_DEPTH > 1) ? $clog2(VS_DEPTH) : 1;
  localparam int unsigned VS_CW = $clog2(VS_DEPTH + 1);
  localparam int unsigned CS_AW = (CS_DEPTH > 1) ? $clog2(CS_DEPTH) : 1;
  localparam int unsigned CS_CW = $clog2(CS_DEPTH + 1);
  localparam int unsigned HP_AW = (HEAP_DEPTH > 1) ? $clog2(HEAP_DEPTH) : 1;
  localparam int unsigned PLEN_W = 17;

  typedef enum logic [4:0] {
    OP_PUSH  = 5'd0,  OP_COPY  = 5'd1,  OP_SLIDE = 5'd2,  OP_DUP   = 5'd3,
    OP_SWAP  = 5'd4,  OP_POP   = 5'd5,  OP_ADD   = 5'd6,  OP_SUB   = 5'd7,
    OP_MUL   = 5'd8,  OP_DIV   = 5'd9,  OP_MOD   = 5'd10, OP_STORE = 5'd11,
    OP_LOAD  = 5'd12, OP_PUTC  = 5'd13, OP_PUTI  = 5'd14, OP_GETC  = 5'd15,
    OP_GETI  = 5'd16, OP_CALL  = 5'd17, OP_JMP   = 5'd18, OP_JZ    = 5'd19,
    OP_JNEG  = 5'd20, OP_RET   = 5'd21, OP_HALT  = 5'd22
  } op_e;

  typedef enum logic [2:0] {
    ERR_NONE  = 3'd0, ERR_PC   = 3'd1, ERR_UNDER = 3'd2, ERR_OVER = 3'd3,
    ERR_CALL  = 3'd4, ERR_HEAP = 3'd5, ERR_DIV0  = 3'd6
  } err_e;

  typedef enum logic [2:0] {
    ST_IDLE, ST_RD_TOP, ST_RD_SEC, ST_EXEC, ST_DIV, ST_WR1, ST_WR2
  } state_e;

  typedef struct packed {
    logic accept;
    logic rd_top;
    logic rd_sec;
    logic exec;
    logic wr1;
    logic wr2;
  } cmd_t;

  typedef struct packed {
    logic div_go;
    logic div_done;
    logic two_writes;
  } status_t;

  localparam int unsigned REG_PROGRAM_LENGTH = 0;

endpackage

// ===== rtl/core/stack_vm_execute_unit.sv =====
// ----------------------------------------------------------------------------
// stack_vm_execute_unit
// Execution core of a stack machine with value stack, call stack and heap.
// ----------------------------------------------------------------------------
// One instruction is taken at a time and yields one result transaction. An
// instruction passes through the states read top, read second, execute and
// write-back, with a second write-back for swap, which writes the value stack
// twice, and a divide state before write-back for div and mod, which run a
// one-bit-per-cycle divider. Its result is registered in the first write-back
// state. This sequence follows from the single read port of each stack and
// heap memory whose read data is registered. A new instruction is accepted
// once the previous result has been taken or is being taken. The program
// length register sits at address 0 of the configuration port.
module stack_vm_execute_unit
  import svm_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [4:0] opcode, [36:5] operand, [68:37] console_value, [71:69] zero
  input  logic [71:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [15:0] next_pc, [16] halted, [17] print_valid, [18] print_is_char,
  // [50:19] print_value, [53:51] error_code, [55:54] zero
  output logic [55:0] m_axis_tdata,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [PLEN_W-1:0] plen_q;
  logic              reg_hit;
  cmd_t              cmd;
  status_t           status;
  logic              out_valid, halted, pv, pic;
  logic [PC_W-1:0]   next_pc;
  logic [31:0]       pval;
  logic [2:0]        err;

  assign pready  = 1'b1;
  assign reg_hit = (paddr[2] == 1'(REG_PROGRAM_LENGTH)) && (paddr[1:0] == 2'b00);
  assign prdata  = reg_hit ? 32'(plen_q) : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      plen_q <= PLEN_W'(1);
    end else if (psel && penable && pwrite && reg_hit) begin
      plen_q <= pwdata[PLEN_W-1:0];
    end
  end

  svm_controller u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .out_busy_i (out_valid && !m_axis_tready),
    .in_ready_o (s_axis_tready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  svm_datapath u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .status_o        (status),
    .plen_i          (plen_q),
    .opcode_i        (s_axis_tdata[4:0]),
    .operand_i       (s_axis_tdata[36:5]),
    .console_i       (s_axis_tdata[68:37]),
    .out_take_i      (m_axis_tready),
    .out_valid_o     (out_valid),
    .next_pc_o       (next_pc),
    .halted_o        (halted),
    .print_valid_o   (pv),
    .print_is_char_o (pic),
    .print_value_o   (pval),
    .error_code_o    (err)
  );

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {2'b00, err, pval, pic, pv, halted, next_pc};

  // An accepted instruction keeps the input closed until it has finished.
  a_one_in_flight : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("instruction accepted while another is in flight");

  a_error_halts : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && (m_axis_tdata[53:51] != ERR_NONE)) |-> m_axis_tdata[16])
    else $error("fault reported without halt");

  a_print_clean : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tdata[17]) |->
      (m_axis_tdata[50:19] == 32'd0) && !m_axis_tdata[18])
    else $error("print fields set without a print");

endmodule

// ===== rtl/core/svm_divider.sv =====
// ----------------------------------------------------------------------------
// svm_divider
// Radix-2 restoring divider, signed, truncating, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module svm_divider
  import svm_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [31:0] dividend_i,
  input  logic [31:0] divisor_i,
  output logic        done_o,
  output logic [31:0] quotient_o,
  output logic [31:0] remainder_o
);

  logic        busy_q, busy_d;
  logic [4:0]  cnt_q, cnt_d;
  logic [31:0] r_q, r_d, q_q, q_d, d_q, d_d;
  logic        qneg_q, qneg_d, rneg_q, rneg_d;
  logic [32:0] trial, diff;

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    r_d    = r_q;
    q_d    = q_q;
    d_d    = d_q;
    qneg_d = qneg_q;
    rneg_d = rneg_q;
    trial  = {r_q, q_q[31]};
    diff   = trial - {1'b0, d_q};
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      r_d    = '0;
      q_d    = dividend_i[31] ? (~dividend_i + 32'd1) : dividend_i;
      d_d    = divisor_i[31] ? (~divisor_i + 32'd1) : divisor_i;
      qneg_d = dividend_i[31] ^ divisor_i[31];
      rneg_d = dividend_i[31];
    end else if (busy_q) begin
      if (!diff[32]) begin
        r_d = diff[31:0];
        q_d = {q_q[30:0], 1'b1};
      end else begin
        r_d = trial[31:0];
        q_d = {q_q[30:0], 1'b0};
      end
      cnt_d = cnt_q + 5'd1;
      if (cnt_q == 5'd31) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    r_q    <= r_d;
    q_q    <= q_d;
    d_q    <= d_d;
    qneg_q <= qneg_d;
    rneg_q <= rneg_d;
  end

  assign done_o      = busy_q && (cnt_q == 5'd31);
  assign quotient_o  = qneg_q ? (~q_q + 32'd1) : q_q;
  assign remainder_o = rneg_q ? (~r_q + 32'd1) : r_q;

endmodule

// ===== rtl/core/svm_datapath.sv =====
// ----------------------------------------------------------------------------
// svm_datapath
// Stacks, heap, program counter, instruction decode and result register.
// ----------------------------------------------------------------------------
module svm_datapath
  import svm_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cmd_t              cmd_i,
  output status_t           status_o,
  input  logic [PLEN_W-1:0] plen_i,
  input  logic [4:0]        opcode_i,
  input  logic [31:0]       operand_i,
  input  logic [31:0]       console_i,
  input  logic              out_take_i,
  output logic              out_valid_o,
  output logic [PC_W-1:0]   next_pc_o,
  output logic              halted_o,
  output logic              print_valid_o,
  output logic              print_is_char_o,
  output logic [31:0]       print_value_o,
  output logic [2:0]        error_code_o
);

  logic [31:0] vs_mem [VS_DEPTH];
  logic [PC_W-1:0] cs_mem [CS_DEPTH];
  logic [31:0] hp_mem [HEAP_DEPTH];

  logic [31:0]     vs_rdata_q, hp_rdata_q;
  logic [PC_W-1:0] cs_rdata_q;
  logic [VS_AW-1:0] vs_raddr;
  logic [HP_AW-1:0] hp_raddr;
  logic [CS_AW-1:0] cs_raddr;

  // Architectural state.
  logic [VS_CW-1:0] cnt_q;
  logic [CS_CW-1:0] csn_q;
  logic [PC_W-1:0]  pc_q;
  logic             stopped_q;

  // Latched instruction and operands.
  logic [4:0]  op_q;
  logic [31:0] opnd_q, cons_q, top_q;

  // Results of the execute step.
  logic             we1_q, we2_q, hwe_q, cwe_q, div_q;
  logic [VS_AW-1:0] wa1_q, wa2_q;
  logic [31:0]      wd1_q, wd2_q, hwd_q;
  logic [HP_AW-1:0] hwa_q;
  logic [PC_W-1:0]  cwd_q, nx_q;
  logic [VS_CW-1:0] cn_q;
  logic [CS_CW-1:0] csn_n_q;
  logic             hlt_q, pv_q, pic_q;
  logic [31:0]      pval_q;
  err_e             err_q;

  logic             we1, we2, hwe, cwe, divgo, hlt, pv, pic, take;
  logic [VS_AW-1:0] wa1, wa2;
  logic [31:0]      wd1, wd2, hwd, pval, sec;
  logic [HP_AW-1:0] hwa;
  logic [PC_W-1:0]  cwd, nx, pc_inc;
  logic [VS_CW-1:0] cn;
  logic [CS_CW-1:0] csn_n;
  logic [1:0]       need;
  logic             grow, depth_bad, tgt_ok, top_heap_ok, sec_heap_ok;
  logic [31:0]      prod;
  err_e             e;

  logic        div_done;
  logic [31:0] quo, rem, wdata1;

  logic             out_valid_q;
  logic [PC_W-1:0]  o_pc_q;
  logic             o_halt_q, o_pv_q, o_pic_q;
  logic [31:0]      o_pval_q;
  logic [2:0]       o_err_q;

  function automatic logic heap_ok(input logic [31:0] a);
    heap_ok = !a[31] && (a < 32'(HEAP_DEPTH));
  endfunction

  always_comb begin
    vs_raddr = VS_AW'(cnt_q - 1'b1);
    if (cmd_i.rd_sec) begin
      vs_raddr = (op_q == OP_COPY) ? VS_AW'(cnt_q - 1'b1 - VS_CW'(opnd_q))
                                   : VS_AW'(cnt_q - VS_CW'(2));
    end
    hp_raddr = vs_rdata_q[HP_AW-1:0];
    cs_raddr = CS_AW'(csn_q - 1'b1);
  end

  assign wdata1 = div_q ? ((op_q == OP_MOD) ? rem : quo) : wd1_q;

  always_ff @(posedge clk_i) begin
    vs_rdata_q <= vs_mem[vs_raddr];
    hp_rdata_q <= hp_mem[hp_raddr];
    cs_rdata_q <= cs_mem[cs_raddr];
    if (cmd_i.wr1 && we1_q) vs_mem[wa1_q] <= wdata1;
    if (cmd_i.wr2 && we2_q) vs_mem[wa2_q] <= wd2_q;
    if (cmd_i.wr1 && hwe_q) hp_mem[hwa_q] <= hwd_q;
    if (cmd_i.wr1 && cwe_q) cs_mem[CS_AW'(csn_q)] <= cwd_q;
  end

  assign sec    = vs_rdata_q;
  assign pc_inc = pc_q + 1'b1;
  assign prod   = sec * top_q;

  always_comb begin
    e     = ERR_NONE;
    nx    = pc_inc;
    hlt   = 1'b0;
    pv    = 1'b0;
    pic   = 1'b0;
    pval  = '0;
    we1   = 1'b0;
    wa1   = VS_AW'(cnt_q);
    wd1   = opnd_q;
    we2   = 1'b0;
    wa2   = VS_AW'(cnt_q - VS_CW'(2));
    wd2   = top_q;
    cn    = cnt_q;
    hwe   = 1'b0;
    hwa   = top_q[HP_AW-1:0];
    hwd   = cons_q;
    cwe   = 1'b0;
    cwd   = pc_inc;
    csn_n = csn_q;
    divgo = 1'b0;
    take  = 1'b0;
    need  = 2'd0;
    grow  = 1'b0;
    case (op_q)
      OP_PUSH: grow = 1'b1;
      OP_COPY, OP_DUP: begin
        need = 2'd1;
        grow = 1'b1;
      end
      OP_SLIDE, OP_POP, OP_LOAD, OP_PUTC, OP_PUTI, OP_GETC, OP_GETI, OP_JZ,
      OP_JNEG: need = 2'd1;
      OP_SWAP, OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_MOD, OP_STORE: need = 2'd2;
      default: need = 2'd0;
    endcase
    depth_bad   = opnd_q[31] || (opnd_q >= 32'(cnt_q));
    tgt_ok      = !opnd_q[31] && (33'(opnd_q) < 33'(plen_i))
                  && ((33'(opnd_q) >> PC_W) == 33'd0);
    top_heap_ok = heap_ok(top_q);
    sec_heap_ok = heap_ok(sec);

    if (stopped_q) begin
      nx = pc_q;
    end else if (33'(pc_q) >= 33'(plen_i)) begin
      e = ERR_PC;
    end else if (cnt_q < VS_CW'(need)) begin
      e = ERR_UNDER;
    end else if (grow && (cnt_q >= VS_CW'(VS_DEPTH))) begin
      e = ERR_OVER;
    end else if (((op_q == OP_COPY) || (op_q == OP_SLIDE)) && depth_bad) begin
      e = ERR_UNDER;
    end else begin
      case (op_q)
        OP_PUSH: begin
          we1 = 1'b1;
          cn  = cnt_q + 1'b1;
        end
        OP_COPY: begin
          we1 = 1'b1;
          wd1 = sec;
          cn  = cnt_q + 1'b1;
        end
        OP_DUP: begin
          we1 = 1'b1;
          wd1 = top_q;
          cn  = cnt_q + 1'b1;
        end
        OP_SLIDE: begin
          cn  = cnt_q - VS_CW'(opnd_q);
          we1 = 1'b1;
          wa1 = VS_AW'(cnt_q - VS_CW'(opnd_q) - 1'b1);
          wd1 = top_q;
        end
        OP_SWAP: begin
          we1 = 1'b1;
          wa1 = VS_AW'(cnt_q - 1'b1);
          wd1 = sec;
          we2 = 1'b1;
        end
        OP_POP: cn = cnt_q - 1'b1;
        OP_ADD, OP_SUB, OP_MUL: begin
          we1 = 1'b1;
          wa1 = VS_AW'(cnt_q - VS_CW'(2));
          cn  = cnt_q - 1'b1;
          case (op_q)
            OP_ADD:  wd1 = sec + top_q;
            OP_SUB:  wd1 = sec - top_q;
            default: wd1 = prod;
          endcase
        end
        OP_DIV, OP_MOD: begin
          if (top_q == 32'd0) begin
            e = ERR_DIV0;
          end else begin
            divgo = 1'b1;
            we1   = 1'b1;
            wa1   = VS_AW'(cnt_q - VS_CW'(2));
            cn    = cnt_q - 1'b1;
          end
        end
        OP_STORE: begin
          if (!sec_heap_ok) begin
            e = ERR_HEAP;
          end else begin
            hwe = 1'b1;
            hwa = sec[HP_AW-1:0];
            hwd = top_q;
            cn  = cnt_q - VS_CW'(2);
          end
        end
        OP_LOAD: begin
          if (!top_heap_ok) begin
            e = ERR_HEAP;
          end else begin
            we1 = 1'b1;
            wa1 = VS_AW'(cnt_q - 1'b1);
            wd1 = hp_rdata_q;
          end
        end
        OP_PUTC, OP_PUTI: begin
          pv   = 1'b1;
          pic  = (op_q == OP_PUTC);
          pval = top_q;
          cn   = cnt_q - 1'b1;
        end
        OP_GETC, OP_GETI: begin
          if (!top_heap_ok) begin
            e = ERR_HEAP;
          end else begin
            hwe = 1'b1;
            cn  = cnt_q - 1'b1;
          end
        end
        OP_CALL: begin
          if (csn_q >= CS_CW'(CS_DEPTH)) begin
            e = ERR_CALL;
          end else if (!tgt_ok) begin
            e = ERR_PC;
          end else begin
            cwe   = 1'b1;
            csn_n = csn_q + 1'b1;
            nx    = opnd_q[PC_W-1:0];
          end
        end
        OP_JMP, OP_JZ, OP_JNEG: begin
          take = (op_q == OP_JMP) || ((op_q == OP_JZ) && (top_q == 32'd0))
                 || ((op_q == OP_JNEG) && top_q[31]);
          if (take && !tgt_ok) begin
            e = ERR_PC;
          end else begin
            if (take) nx = opnd_q[PC_W-1:0];
            if (op_q != OP_JMP) cn = cnt_q - 1'b1;
          end
        end
        OP_RET: begin
          if (csn_q == '0) begin
            e = ERR_CALL;
          end else begin
            csn_n = csn_q - 1'b1;
            nx    = cs_rdata_q;
          end
        end
        OP_HALT: begin
          hlt = 1'b1;
          nx  = pc_q;
        end
        default: ;
      endcase
    end

    if (e != ERR_NONE) begin
      hlt   = 1'b1;
      nx    = pc_q;
      pv    = 1'b0;
      pic   = 1'b0;
      pval  = '0;
      we1   = 1'b0;
      we2   = 1'b0;
      hwe   = 1'b0;
      cwe   = 1'b0;
      divgo = 1'b0;
      cn    = cnt_q;
      csn_n = csn_q;
    end
  end

  svm_divider u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (cmd_i.exec && divgo),
    .dividend_i  (sec),
    .divisor_i   (top_q),
    .done_o      (div_done),
    .quotient_o  (quo),
    .remainder_o (rem)
  );

  assign status_o.div_go     = divgo;
  assign status_o.div_done   = div_done;
  assign status_o.two_writes = we2_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      op_q   <= opcode_i;
      opnd_q <= operand_i;
      cons_q <= console_i;
    end
    if (cmd_i.rd_sec) top_q <= vs_rdata_q;
    if (cmd_i.exec) begin
      wa1_q   <= wa1;
      wd1_q   <= wd1;
      wa2_q   <= wa2;
      wd2_q   <= wd2;
      hwa_q   <= hwa;
      hwd_q   <= hwd;
      cwd_q   <= cwd;
      nx_q    <= nx;
      cn_q    <= cn;
      csn_n_q <= csn_n;
      hlt_q   <= hlt || stopped_q;
      pv_q    <= pv;
      pic_q   <= pic;
      pval_q  <= pval;
      err_q   <= e;
      div_q   <= divgo;
    end
    if (cmd_i.wr1) begin
      o_pc_q   <= nx_q;
      o_halt_q <= hlt_q;
      o_pv_q   <= pv_q;
      o_pic_q  <= pic_q;
      o_pval_q <= pval_q;
      o_err_q  <= err_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      csn_q       <= '0;
      pc_q        <= '0;
      stopped_q   <= 1'b0;
      we1_q       <= 1'b0;
      we2_q       <= 1'b0;
      hwe_q       <= 1'b0;
      cwe_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.exec) begin
        we1_q <= we1;
        we2_q <= we2;
        hwe_q <= hwe;
        cwe_q <= cwe;
      end
      if (cmd_i.wr1) begin
        cnt_q     <= cn_q;
        csn_q     <= csn_n_q;
        pc_q      <= nx_q;
        stopped_q <= hlt_q;
      end
      if (cmd_i.wr1) begin
        out_valid_q <= 1'b1;
      end else if (out_take_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o     = out_valid_q;
  assign next_pc_o       = o_pc_q;
  assign halted_o        = o_halt_q;
  assign print_valid_o   = o_pv_q;
  assign print_is_char_o = o_pic_q;
  assign print_value_o   = o_pval_q;
  assign error_code_o    = o_err_q;

endmodule

// ===== rtl/core/svm_controller.sv =====
// ----------------------------------------------------------------------------
// svm_controller
// Sequencer for read, execute, divide and write-back of one instruction.
// ----------------------------------------------------------------------------
module svm_controller
  import svm_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  input  logic    out_busy_i,
  output logic    in_ready_o,
  input  status_t status_i,
  output cmd_t    cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = !out_busy_i;
        if (in_valid_i && !out_busy_i) begin
          cmd_o.accept = 1'b1;
          state_d      = ST_RD_TOP;
        end
      end
      ST_RD_TOP: begin
        cmd_o.rd_top = 1'b1;
        state_d      = ST_RD_SEC;
      end
      ST_RD_SEC: begin
        cmd_o.rd_sec = 1'b1;
        state_d      = ST_EXEC;
      end
      ST_EXEC: begin
        cmd_o.exec = 1'b1;
        state_d    = status_i.div_go ? ST_DIV : ST_WR1;
      end
      ST_DIV: begin
        if (status_i.div_done) state_d = ST_WR1;
      end
      ST_WR1: begin
        cmd_o.wr1 = 1'b1;
        state_d   = status_i.two_writes ? ST_WR2 : ST_IDLE;
      end
      ST_WR2: begin
        cmd_o.wr2 = 1'b1;
        state_d   = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule
